### design/fifo_with_search_and_delete_assert.svh
// Assertion macros for the queue datapath.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef FIFO_WITH_SEARCH_AND_DELETE_ASSERT_SVH
`define FIFO_WITH_SEARCH_AND_DELETE_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define FSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define FSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/fsd_pkg.sv
// Shared types and constants of the searchable queue.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package fsd_pkg;

	localparam int FSD_DEPTH = 16;
	localparam int DATA_W    = 32;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 5;

	localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_OP,
		RD_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic                latch_in;
		logic                rd_en;
		rd_sel_t             rd_sel;
		logic                wr_en;
		logic                wr_shift;
		logic                cnt_inc;
		logic                cnt_dec;
		logic                idx_clr;
		logic                idx_inc;
		logic                st_set;
		logic [STATUS_W-1:0] st_code;
		logic                data_set;
		logic                pos_set;
		logic                load_out;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              empty;
		logic              bad_pos;
		logic              match;
		logic              next_last;
		logic              out_free;
	} sts_t;

endpackage

### design/fifo_with_search_and_delete.sv
// Top level of the bounded queue with search and delete.
// Depends on fsd_pkg, fsd_ctrl and fsd_dp.
`timescale 1ns / 1ps

// Usage. The input channel (in_valid, in_ready, mode, operand) carries one
// beat per operation: push, pop, read at a position, search, or delete.
// The output channel (out_valid, out_ready, status, data, position, level)
// returns exactly one result beat for every input beat, in order.
// One operation is worked on at a time; in_ready is high only between them.
// Push, unused modes and error cases go from dispatch straight to the
// finish state; read captures the requested entry; pop captures the head
// and closes the gap behind it; search scans from the head, and delete
// scans and then closes the gap. The time taken is set by the single read
// port of the entry memory: the scan reads one entry a cycle, and closing
// a gap moves each later entry with a read step followed by a write step.
// A new beat is taken in the cycle after the result is loaded, so the next
// operation starts while the previous result still waits for out_ready.
// If the receiver stalls, the finished result holds in the output register
// and the sequencer waits before loading the next one.
// Reset (arst_n low) empties the queue and drops any pending result; the
// memory contents are not cleared, since only held entries are ever read.

module fifo_with_search_and_delete #(
	parameter int DEPTH = fsd_pkg::FSD_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fsd_pkg::MODE_W-1:0]        mode,
	input  logic signed [fsd_pkg::DATA_W-1:0] operand,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fsd_pkg::STATUS_W-1:0]      status,
	output logic signed [fsd_pkg::DATA_W-1:0] data,
	output logic [fsd_pkg::POS_W-1:0]         position,
	output logic [fsd_pkg::POS_W-1:0]         level
);

	import fsd_pkg::*;

	// Commands from the sequencer and the status flags that steer it.
	cmd_t cmd;
	sts_t sts;

	fsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath latches the beat when the sequencer accepts it.
	fsd_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode),
		.operand   (operand),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data      (data),
		.position  (position),
		.level     (level)
	);

endmodule

### design/fsd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module fsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/fsd_ctrl.sv
// Sequencer of the searchable queue: accepts a beat and steps the datapath.
// Depends on fsd_pkg.
`timescale 1ns / 1ps

module fsd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fsd_pkg::sts_t sts,
	output fsd_pkg::cmd_t cmd
);

	import fsd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_CAPTURE,
		S_SCAN,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   in_ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready_q) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				unique case (sts.mode)
					MODE_PUSH: begin
						if (sts.full) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_FULL;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.cnt_inc = 1'b1;
						end
					end
					MODE_POP: begin
						if (sts.empty) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_EMPTY;
						end else begin
							cmd.rd_en   = 1'b1;
							cmd.rd_sel  = RD_ZERO;
							cmd.idx_clr = 1'b1;
							state_d     = S_CAPTURE;
						end
					end
					MODE_READ: begin
						if (sts.empty) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_EMPTY;
						end else if (sts.bad_pos) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_RANGE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_OP;
							state_d    = S_CAPTURE;
						end
					end
					MODE_SEARCH, MODE_DELETE: begin
						if (sts.empty) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = ST_EMPTY;
						end else begin
							cmd.rd_en   = 1'b1;
							cmd.rd_sel  = RD_ZERO;
							cmd.idx_clr = 1'b1;
							state_d     = S_SCAN;
						end
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_CAPTURE: begin
				cmd.data_set = 1'b1;
				state_d      = (sts.mode == MODE_POP) ? S_SHIFT_RD : S_FINISH;
			end
			S_SCAN: begin
				if (sts.match) begin
					cmd.pos_set = 1'b1;
					state_d     = (sts.mode == MODE_DELETE) ? S_SHIFT_RD : S_FINISH;
				end else if (sts.next_last) begin
					cmd.st_set  = 1'b1;
					cmd.st_code = ST_EMPTY;
					state_d     = S_FINISH;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_NEXT;
					cmd.idx_inc = 1'b1;
				end
			end
			S_SHIFT_RD: begin
				if (sts.next_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d    = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			in_ready_q <= (state_d == S_IDLE);
		end
	end

	assign in_ready = in_ready_q;

endmodule

### design/fsd_dp.sv
// Datapath of the searchable queue: entry memory, fill count, scan index
// and the result register. Depends on fsd_pkg, fsd_ram and the assertion header.
`timescale 1ns / 1ps

`include "fifo_with_search_and_delete_assert.svh"

module fsd_dp #(
	parameter int DEPTH = fsd_pkg::FSD_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [fsd_pkg::MODE_W-1:0]          mode,
	input  logic signed [fsd_pkg::DATA_W-1:0]   operand,
	input  fsd_pkg::cmd_t                       cmd,
	output fsd_pkg::sts_t                       sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fsd_pkg::STATUS_W-1:0]        status,
	output logic signed [fsd_pkg::DATA_W-1:0]   data,
	output logic [fsd_pkg::POS_W-1:0]           position,
	output logic [fsd_pkg::POS_W-1:0]           level
);

	import fsd_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [MODE_W-1:0]        mode_q;
	logic [DATA_W-1:0]        op_q;
	logic [CW-1:0]            count_q;
	logic [IW-1:0]            idx_q;
	logic [CW-1:0]            idx_nxt;
	logic [STATUS_W-1:0]      status_q;
	logic [DATA_W-1:0]        data_q;
	logic [POS_W-1:0]         pos_q;

	logic                     out_valid_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic [DATA_W-1:0]        out_data_q;
	logic [POS_W-1:0]         out_pos_q;
	logic [POS_W-1:0]         out_level_q;

	logic                     ram_wr_en;
	logic [IW-1:0]            ram_wr_addr;
	logic [DATA_W-1:0]        ram_wr_data;
	logic [IW-1:0]            ram_rd_addr;
	logic [DATA_W-1:0]        ram_rd_data;

	assign idx_nxt = CW'(idx_q) + CW'(1);

	// Read addresses: head, requested position, or the entry after the index.
	always_comb begin
		unique case (cmd.rd_sel)
			RD_ZERO: ram_rd_addr = '0;
			RD_OP:   ram_rd_addr = op_q[IW-1:0];
			RD_NEXT: ram_rd_addr = idx_nxt[IW-1:0];
			default: ram_rd_addr = '0;
		endcase
	end

	// A push writes the tail; a shift step moves the next entry down by one.
	assign ram_wr_en   = cmd.wr_en;
	assign ram_wr_addr = cmd.wr_shift ? idx_q : count_q[IW-1:0];
	assign ram_wr_data = cmd.wr_shift ? ram_rd_data : op_q;

	fsd_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			mode_q   <= mode;
			op_q     <= operand;
			status_q <= ST_OK;
			data_q   <= '0;
			pos_q    <= '0;
		end else begin
			if (cmd.st_set) begin
				status_q <= cmd.st_code;
			end
			if (cmd.data_set) begin
				data_q <= ram_rd_data;
			end
			if (cmd.pos_set) begin
				pos_q <= POS_W'(idx_nxt);
			end
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_nxt[IW-1:0];
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_data_q   <= data_q;
			out_pos_q    <= pos_q;
			out_level_q  <= POS_W'(count_q);
		end
	end

	assign sts.mode      = mode_q;
	assign sts.full      = (count_q >= CW'(DEPTH));
	assign sts.empty     = (count_q == '0);
	assign sts.bad_pos   = op_q[DATA_W-1] || (op_q >= DATA_W'(count_q));
	assign sts.match     = (ram_rd_data == op_q);
	assign sts.next_last = (idx_nxt >= count_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign data      = out_data_q;
	assign position  = out_pos_q;
	assign level     = out_level_q;

	`FSD_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "fill count above depth")
	`FSD_ASSERT(a_push_room, clk, arst_n, (cmd.wr_en && !cmd.wr_shift) |-> (count_q < CW'(DEPTH)), "push written while full")
	`FSD_ASSERT(a_shift_inside, clk, arst_n, (cmd.wr_en && cmd.wr_shift) |-> (idx_nxt < count_q), "shift step beyond the held entries")
	`FSD_ASSERT(a_count_one_way, clk, arst_n, !(cmd.cnt_inc && cmd.cnt_dec), "fill count moved both ways at once")

endmodule

### dv/fifo_with_search_and_delete_test.sv
// Self-checking testbench for the searchable queue fifo_with_search_and_delete.
// Depends on fsd_pkg and the RTL of the block; it needs no other file.
`timescale 1ns / 1ps

// The bench drives the input channel one beat at a time and keeps its own
// model of the queue. The model is updated when a beat is accepted, and the
// result that the beat must produce is queued. Every result beat that leaves
// the block is compared, field by field, with the oldest queued result.
//
// The run has three parts. A short scripted part opens it. It covers the
// empty queue, the full queue, the word extremes, reads out of range,
// searches that miss, deletion of the head entry, and the unused modes.
// Four random phases follow, each with its own idling on the two sides.
// The last is the drain at the end. A watchdog ends the run when no beat
// moves on either channel for too long.

module fifo_with_search_and_delete_test;
	import fsd_pkg::*;

	localparam int DEPTH       = FSD_DEPTH;
	localparam int QUIET_LIMIT = 4000;
	localparam int REPORT_MAX  = 10;
	localparam int PHASE_BEATS = 262;
	localparam int SETTLE      = 80;

	// Modes 5 to 7 do nothing, but they still return a result beat.
	localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] data;
		logic [POS_W-1:0]         position;
		logic [POS_W-1:0]         level;
	} qresult_t;

	// One line of the scripted part. A line is repeated reps times, and its
	// operand grows by one on each repeat. When typed is set, the result is
	// written into the line; otherwise it comes from the queue model.
	typedef struct packed {
		logic [MODE_W-1:0]        op_mode;
		logic signed [DATA_W-1:0] arg;
		logic [5:0]               reps;
		bit                       typed;
		qresult_t                 want;
	} script_line_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [MODE_W-1:0]          mode;
	logic signed [DATA_W-1:0]   operand;
	logic                       out_valid;
	logic                       out_ready;
	logic [STATUS_W-1:0]        status;
	logic signed [DATA_W-1:0]   data;
	logic [POS_W-1:0]           position;
	logic [POS_W-1:0]           level;

	// The queue model. The head sits at index 0.
	logic signed [DATA_W-1:0] model_words [DEPTH];
	int                       model_held = 0;

	qresult_t     pending_results [$];
	script_line_t script [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int quiet_cycles   = 0;

	fifo_with_search_and_delete #(
		.DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.operand  (operand),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.data     (data),
		.position (position),
		.level    (level)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one operation to the queue model and return the result that the
	// block must give for it. Pop and delete share the code that closes the gap.
	function automatic qresult_t queue_apply(input logic [MODE_W-1:0] m,
			input logic signed [DATA_W-1:0] v);
		qresult_t r;
		int hit;
		int drop;
		r = '0;
		hit = -1;
		drop = -1;
		case (m)
		MODE_PUSH: begin
			if (model_held == DEPTH) begin
				r.status = ST_FULL;
			end else begin
				model_words[model_held] = v;
				model_held++;
			end
		end
		MODE_POP: begin
			if (model_held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.data = model_words[0];
				drop = 0;
			end
		end
		MODE_READ: begin
			if (model_held == 0) begin
				r.status = ST_EMPTY;
			end else if (v < 0 || v >= model_held) begin
				r.status = ST_RANGE;
			end else begin
				r.data = model_words[v];
			end
		end
		MODE_SEARCH, MODE_DELETE: begin
			for (int i = 0; i < model_held; i++) begin
				if (hit < 0 && model_words[i] == v)
					hit = i;
			end
			if (hit < 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.position = POS_W'(hit + 1);
				if (m == MODE_DELETE)
					drop = hit;
			end
		end
		default: ;
		endcase
		if (drop >= 0) begin
			for (int k = drop; k < model_held - 1; k++)
				model_words[k] = model_words[k + 1];
			model_held--;
		end
		r.level = POS_W'(model_held);
		return r;
	endfunction

	// A word from a small pool. The pool repeats values so that searches
	// and deletes often have to pick the first of several matches.
	function automatic logic signed [DATA_W-1:0] pool_word();
		case ($urandom_range(7))
		0: return '0;
		1: return -1;
		2: return WORD_MAX;
		3: return WORD_MIN;
		4: return 1;
		default: return $urandom_range(9, 2);
		endcase
	endfunction

	// Offer one beat and wait until it is accepted. Then record the result
	// that it must produce. Valid drops only in the idle cycles before the
	// beat, so it is never lowered and raised again in the same time step.
	task automatic send_beat(input logic [MODE_W-1:0] m,
			input logic signed [DATA_W-1:0] v, input bit typed, input qresult_t want);
		qresult_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		operand <= v;
		do @(posedge clk); while (!in_ready);
		predicted = queue_apply(m, v);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Hold the input channel off until every outstanding result has come back.
	// The task waits on the clock before its first check, so the low valid is seen.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic add_line(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v,
			input int reps, input bit typed, input logic [STATUS_W-1:0] st,
			input logic signed [DATA_W-1:0] d, input int p, input int lvl);
		script_line_t line;
		line.op_mode = m;
		line.arg = v;
		line.reps = 6'(reps);
		line.typed = typed;
		line.want.status = st;
		line.want.data = d;
		line.want.position = POS_W'(p);
		line.want.level = POS_W'(lvl);
		script.push_back(line);
	endtask

	// Build one random beat. A grow block mostly pushes, and a shrink block
	// mostly pops and deletes. Alternating the two takes the queue from empty
	// to full and back many times. Most searches, deletes and reads aim at
	// entries that the queue holds, so that they reach the shifting logic.
	task automatic random_beat(input bit grow);
		int pick;
		logic [MODE_W-1:0] m;
		logic signed [DATA_W-1:0] v;
		pick = $urandom_range(99);
		v = $urandom;
		if (pick < 3)
			m = MODE_W'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
		else if (pick < (grow ? 58 : 18))
			m = MODE_PUSH;
		else if (pick < (grow ? 68 : 50))
			m = MODE_POP;
		else if (pick < (grow ? 80 : 63))
			m = MODE_READ;
		else if (pick < (grow ? 90 : 76))
			m = MODE_SEARCH;
		else
			m = MODE_DELETE;
		case (m)
		MODE_PUSH: begin
			// One push in five keeps a fully random word, so that every
			// bit of the operand takes both values.
			if ($urandom_range(4) != 0)
				v = pool_word();
		end
		MODE_READ: begin
			pick = $urandom_range(9);
			if (model_held > 0 && pick < 8)
				v = $urandom_range(model_held - 1);
			else if (pick == 8)
				v = $urandom_range(DEPTH + 3, model_held);
			else
				v = $urandom | WORD_MIN;
		end
		MODE_SEARCH, MODE_DELETE: begin
			if (model_held > 0 && $urandom_range(9) < 7)
				v = model_words[$urandom_range(model_held - 1)];
			else if ($urandom_range(1) == 1)
				v = pool_word();
		end
		default: ;
		endcase
		send_beat(m, v, 1'b0, '0);
	endtask

	// One random phase with the given idling. Blocks of random length
	// alternate between growing and shrinking the queue. Now and then the
	// sender waits until every outstanding result has come back.
	task automatic run_phase(input int send_pct, input int recv_pct);
		int done;
		int block_len;
		bit grow;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		done = 0;
		grow = 1'b1;
		while (done < PHASE_BEATS) begin
			block_len = $urandom_range(40, 10);
			for (int k = 0; k < block_len && done < PHASE_BEATS; k++) begin
				random_beat(grow);
				done++;
			end
			grow = !grow;
			if ($urandom_range(3) == 0)
				drain_results();
		end
		drain_results();
	endtask

	// Each cycle, the receiver drops out_ready with the chance that the
	// current phase sets.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result checker. It also counts the cycles in which no beat moves on
	// either channel, for the watchdog.
	always @(posedge clk) begin : check_results
		qresult_t got;
		qresult_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (out_valid && out_ready) begin
				got.status = status;
				got.data = data;
				got.position = position;
				got.level = level;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result beat with no operation outstanding", $realtime);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.data !== want.data ||
							got.position !== want.position || got.level !== want.level) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$write("%0t: result mismatch, expected status %0d data %0d ",
								$realtime, want.status, want.data);
							$write("position %0d level %0d, ", want.position, want.level);
							$display("got status %0d data %0d position %0d level %0d",
								got.status, got.data, got.position, got.level);
						end
					end
				end
			end
		end
	end

	// The watchdog fires when nothing has moved on either channel for too
	// long. That covers a block that hangs and a result that never comes.
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("fifo_with_search_and_delete regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_PUSH;
		operand = '0;
		out_ready = 1'b0;

		// The scripted part. Levels are counted by hand from the empty queue.
		add_line(MODE_POP,          0,        1,  1, ST_EMPTY, 0,        0,  0);
		add_line(MODE_READ,         0,        1,  1, ST_EMPTY, 0,        0,  0);
		add_line(MODE_SEARCH,       0,        1,  1, ST_EMPTY, 0,        0,  0);
		add_line(MODE_DELETE,       0,        1,  1, ST_EMPTY, 0,        0,  0);
		add_line(MODE_UNUSED_FIRST, -1,       1,  1, ST_OK,    0,        0,  0);
		add_line(MODE_UNUSED_LAST,  WORD_MIN, 1,  1, ST_OK,    0,        0,  0);
		// Zero is an ordinary value and must be stored like any other word.
		add_line(MODE_PUSH,         0,        1,  1, ST_OK,    0,        0,  1);
		add_line(MODE_PUSH,         WORD_MAX, 1,  1, ST_OK,    0,        0,  2);
		add_line(MODE_PUSH,         WORD_MIN, 1,  1, ST_OK,    0,        0,  3);
		add_line(MODE_READ,         -1,       1,  1, ST_RANGE, 0,        0,  3);
		add_line(MODE_READ,         3,        1,  1, ST_RANGE, 0,        0,  3);
		add_line(MODE_READ,         2,        1,  1, ST_OK,    WORD_MIN, 0,  3);
		// Fill the queue with 100 to 112, then push once more into a full queue.
		add_line(MODE_PUSH,         100,      13, 0, ST_OK,    0,        0,  0);
		add_line(MODE_PUSH,         1,        1,  1, ST_FULL,  0,        0,  16);
		add_line(MODE_SEARCH,       WORD_MIN, 1,  1, ST_OK,    0,        3,  16);
		// Delete the head entry, and later the tail entry.
		add_line(MODE_DELETE,       0,        1,  1, ST_OK,    0,        1,  15);
		add_line(MODE_READ,         15,       1,  1, ST_RANGE, 0,        0,  15);
		add_line(MODE_DELETE,       112,      1,  1, ST_OK,    0,        15, 14);
		add_line(MODE_SEARCH,       999,      1,  1, ST_EMPTY, 0,        0,  14);
		add_line(MODE_POP,          0,        1,  1, ST_OK,    WORD_MAX, 0,  13);
		add_line(MODE_UNUSED_FIRST + 3'd1, 7, 1,  1, ST_OK,    0,        0,  13);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			for (int k = 0; k < script[i].reps; k++)
				send_beat(script[i].op_mode, script[i].arg + k, script[i].typed,
					script[i].want);
		end
		drain_results();

		// Random phases: no idling, then a slow sender, then a stalling
		// receiver, then light idling on both sides.
		run_phase(0, 0);
		run_phase(51, 0);
		run_phase(0, 51);
		run_phase(8, 8);

		// Keep the receiver ready for a while, so that any stray result beat
		// is caught before the verdict.
		recv_stall_pct = 0;
		repeat (SETTLE) @(posedge clk);
		mismatches += pending_results.size();
		if (mismatches == 0)
			$display("fifo_with_search_and_delete regression: pass");
		else
			$display("fifo_with_search_and_delete regression: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/fsd_pkg.sv
design/fsd_ram.sv
design/fsd_ctrl.sv
design/fsd_dp.sv
design/fifo_with_search_and_delete.sv
dv/fifo_with_search_and_delete_test.sv
